### hdl/pcc_pkg.sv
package pcc_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int NUM_W     = DATA_W + FRAC_W;
  localparam int CNT_W     = $clog2(NUM_W);
  localparam int PC_W      = 4;
  localparam int CFG_IDX_W = 3;
  localparam int OP_W      = 4;
  localparam int MS_W      = 3;
  localparam int J_W       = 2;

  typedef logic signed [DATA_W-1:0] val_t;
  typedef logic [DATA_W-1:0]        mag_t;
  typedef logic [PROD_W-1:0]        prod_t;

  localparam val_t  VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam val_t  VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam prod_t MAG_LIM = prod_t'(1) << (DATA_W - 1);

  typedef struct packed {
    logic signed [DATA_W-1:0] reference;
    logic signed [DATA_W-1:0] measurement;
    logic [DATA_W-1:0]        time_step;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     clamped;
  } out_item_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_METHOD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDUP_CLEAR = 3'd6;

  // datapath operations
  localparam logic [OP_W-1:0] OP_NOP      = 4'd0;
  localparam logic [OP_W-1:0] OP_ERR      = 4'd1;
  localparam logic [OP_W-1:0] OP_TERM     = 4'd2;
  localparam logic [OP_W-1:0] OP_ACC_INT  = 4'd3;
  localparam logic [OP_W-1:0] OP_DIV_INIT = 4'd4;
  localparam logic [OP_W-1:0] OP_DIV_STEP = 4'd5;
  localparam logic [OP_W-1:0] OP_DIV_END  = 4'd6;
  localparam logic [OP_W-1:0] OP_ADD_P    = 4'd7;
  localparam logic [OP_W-1:0] OP_ADD_I    = 4'd8;
  localparam logic [OP_W-1:0] OP_ADD_D    = 4'd9;
  localparam logic [OP_W-1:0] OP_CLAMP    = 4'd10;

  // multiplier operand sources
  localparam logic [MS_W-1:0] MS_NONE = 3'd0;
  localparam logic [MS_W-1:0] MS_TERM = 3'd1;
  localparam logic [MS_W-1:0] MS_P    = 3'd2;
  localparam logic [MS_W-1:0] MS_I    = 3'd3;
  localparam logic [MS_W-1:0] MS_D    = 3'd4;

  // sequencing
  localparam logic [J_W-1:0] J_NEXT = 2'd0;
  localparam logic [J_W-1:0] J_LOOP = 2'd1;
  localparam logic [J_W-1:0] J_DONE = 2'd2;

  // program addresses
  localparam logic [PC_W-1:0] PC_ERR   = 4'd0;
  localparam logic [PC_W-1:0] PC_TERM  = 4'd1;
  localparam logic [PC_W-1:0] PC_MTERM = 4'd2;
  localparam logic [PC_W-1:0] PC_ACC   = 4'd3;
  localparam logic [PC_W-1:0] PC_DINIT = 4'd4;
  localparam logic [PC_W-1:0] PC_DSTEP = 4'd5;
  localparam logic [PC_W-1:0] PC_DEND  = 4'd6;
  localparam logic [PC_W-1:0] PC_MP    = 4'd7;
  localparam logic [PC_W-1:0] PC_AP    = 4'd8;
  localparam logic [PC_W-1:0] PC_MI    = 4'd9;
  localparam logic [PC_W-1:0] PC_AI    = 4'd10;
  localparam logic [PC_W-1:0] PC_MD    = 4'd11;
  localparam logic [PC_W-1:0] PC_AD    = 4'd12;
  localparam logic [PC_W-1:0] PC_CLAMP = 4'd13;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [MS_W-1:0] msrc;
    logic [J_W-1:0]  jmp;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic            load;
    logic            en;
    logic [OP_W-1:0] op;
    logic [MS_W-1:0] msrc;
  } ctrl_t;

  typedef struct packed {
    logic div_last;
    logic out_hold;
  } stat_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      PC_ERR:   w = {OP_ERR,      MS_NONE, J_NEXT, PC_ERR};
      PC_TERM:  w = {OP_TERM,     MS_NONE, J_NEXT, PC_ERR};
      PC_MTERM: w = {OP_NOP,      MS_TERM, J_NEXT, PC_ERR};
      PC_ACC:   w = {OP_ACC_INT,  MS_NONE, J_NEXT, PC_ERR};
      PC_DINIT: w = {OP_DIV_INIT, MS_NONE, J_NEXT, PC_ERR};
      PC_DSTEP: w = {OP_DIV_STEP, MS_NONE, J_LOOP, PC_DSTEP};
      PC_DEND:  w = {OP_DIV_END,  MS_NONE, J_NEXT, PC_ERR};
      PC_MP:    w = {OP_NOP,      MS_P,    J_NEXT, PC_ERR};
      PC_AP:    w = {OP_ADD_P,    MS_NONE, J_NEXT, PC_ERR};
      PC_MI:    w = {OP_NOP,      MS_I,    J_NEXT, PC_ERR};
      PC_AI:    w = {OP_ADD_I,    MS_NONE, J_NEXT, PC_ERR};
      PC_MD:    w = {OP_NOP,      MS_D,    J_NEXT, PC_ERR};
      PC_AD:    w = {OP_ADD_D,    MS_NONE, J_NEXT, PC_ERR};
      PC_CLAMP: w = {OP_CLAMP,    MS_NONE, J_DONE, PC_ERR};
      default:  w = {OP_NOP,      MS_NONE, J_DONE, PC_ERR};
    endcase
    return w;
  endfunction

  function automatic mag_t mag_of(input val_t a);
    mag_t m;
    m = a[DATA_W-1] ? mag_t'(0) - mag_t'(a) : mag_t'(a);
    return m;
  endfunction

  function automatic val_t sadd(input val_t a, input val_t b);
    logic [DATA_W:0] s;
    val_t r;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) r = s[DATA_W] ? VAL_MIN : VAL_MAX;
    else r = val_t'(s[DATA_W-1:0]);
    return r;
  endfunction

  function automatic val_t ssub(input val_t a, input val_t b);
    logic [DATA_W:0] s;
    val_t r;
    s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) r = s[DATA_W] ? VAL_MIN : VAL_MAX;
    else r = val_t'(s[DATA_W-1:0]);
    return r;
  endfunction

  // mean rounded toward minus infinity
  function automatic val_t fmean(input val_t a, input val_t b);
    logic [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    return val_t'(s[DATA_W:1]);
  endfunction

  // sign and magnitude back to a saturated value
  function automatic val_t sat_mag(input logic neg, input prod_t m);
    mag_t lowm;
    val_t r;
    lowm = m[DATA_W-1:0];
    if (neg) r = (m >= MAG_LIM) ? VAL_MIN : val_t'(mag_t'(0) - lowm);
    else r = (m >= MAG_LIM) ? VAL_MAX : val_t'(lowm);
    return r;
  endfunction

endpackage

### hdl/pcc_in_if.sv
interface pcc_in_if;
  import pcc_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/pcc_out_if.sv
interface pcc_out_if;
  import pcc_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/pcc_seq.sv
module pcc_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pcc_pkg::stat_t  stat,
  output pcc_pkg::ctrl_t  ctrl
);
  import pcc_pkg::*;

  logic            busy_r, busy_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  uword_t          uw;
  logic            load, stall, en;

  assign uw       = ucode(pc_r);
  assign in_ready = !busy_r;
  assign load     = in_valid && !busy_r;
  // the final step waits until the output register is free
  assign stall    = (uw.jmp == J_DONE) && stat.out_hold;
  assign en       = busy_r && !stall;

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (load) begin
      busy_nxt = 1'b1;
      pc_nxt   = PC_ERR;
    end else if (en) begin
      case (uw.jmp)
        J_NEXT: pc_nxt = pc_r + 1'b1;
        J_LOOP: pc_nxt = stat.div_last ? pc_r + 1'b1 : uw.target;
        J_DONE: begin
          busy_nxt = 1'b0;
          pc_nxt   = PC_ERR;
        end
        default: begin
          busy_nxt = 1'b0;
          pc_nxt   = PC_ERR;
        end
      endcase
    end
  end

  assign ctrl = '{load: load, en: en, op: uw.op, msrc: uw.msrc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= PC_ERR;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end
endmodule

### hdl/pcc_dpath.sv
module pcc_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pcc_pkg::ctrl_t                    ctrl,
  output pcc_pkg::stat_t                    stat,
  input  pcc_pkg::in_item_t                 in_data,
  input  logic                              cfg_we,
  input  logic [pcc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [pcc_pkg::DATA_W-1:0]        cfg_wdata,
  output logic                              out_valid,
  input  logic                              out_ready,
  output pcc_pkg::out_item_t                out_data
);
  import pcc_pkg::*;

  // configuration
  val_t gp_r, gi_r, gd_r, lo_r, hi_r;
  logic method_r, windup_r;

  // item operands and working registers
  val_t ref_r, meas_r;
  mag_t dt_r;
  val_t e_r, last_r, integ_r, term_r, diff_r, deriv_r, u_r;

  prod_t prod_r;
  logic  prod_neg_r;

  logic [NUM_W-1:0] num_r;
  mag_t             rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             dneg_r;

  logic out_valid_r, out_valid_nxt;
  val_t drive_r;
  logic clip_r;

  mag_t            mul_a, mul_b;
  logic            mul_neg;
  val_t            fix_v;
  logic [DATA_W:0] rem_sh, rem_dif;
  logic            qbit;
  logic            below, above, clip, do_clamp;

  always_comb begin
    case (ctrl.msrc)
      MS_TERM: begin
        mul_a   = mag_of(term_r);
        mul_b   = dt_r;
        mul_neg = term_r[DATA_W-1];
      end
      MS_P: begin
        mul_a   = mag_of(gp_r);
        mul_b   = mag_of(e_r);
        mul_neg = gp_r[DATA_W-1] ^ e_r[DATA_W-1];
      end
      MS_I: begin
        mul_a   = mag_of(gi_r);
        mul_b   = mag_of(integ_r);
        mul_neg = gi_r[DATA_W-1] ^ integ_r[DATA_W-1];
      end
      MS_D: begin
        mul_a   = mag_of(gd_r);
        mul_b   = mag_of(deriv_r);
        mul_neg = gd_r[DATA_W-1] ^ deriv_r[DATA_W-1];
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
      end
    endcase
  end

  // product magnitude scaled down, truncating toward zero
  assign fix_v = sat_mag(prod_neg_r, prod_r >> FRAC_W);

  // restoring divider, one quotient bit per step
  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign rem_dif = rem_sh - {1'b0, dt_r};
  assign qbit    = rem_sh >= {1'b0, dt_r};

  // low limit has priority when the limits are crossed
  assign below    = u_r < lo_r;
  assign above    = u_r > hi_r;
  assign clip     = below || above;
  assign do_clamp = ctrl.en && (ctrl.op == OP_CLAMP);

  assign out_valid_nxt = (out_valid_r && !out_ready) || do_clamp;

  assign stat.div_last = (cnt_r == '0);
  assign stat.out_hold = out_valid_r && !out_ready;

  assign out_valid        = out_valid_r;
  assign out_data.drive   = drive_r;
  assign out_data.clamped = clip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gp_r        <= '0;
      gi_r        <= '0;
      gd_r        <= '0;
      lo_r        <= VAL_MIN;
      hi_r        <= VAL_MAX;
      method_r    <= 1'b0;
      windup_r    <= 1'b1;
      last_r      <= '0;
      integ_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_GAIN_PROP:    gp_r     <= val_t'(cfg_wdata);
          CFG_GAIN_INTEG:   gi_r     <= val_t'(cfg_wdata);
          CFG_GAIN_DERIV:   gd_r     <= val_t'(cfg_wdata);
          CFG_OUT_MIN:      lo_r     <= val_t'(cfg_wdata);
          CFG_OUT_MAX:      hi_r     <= val_t'(cfg_wdata);
          CFG_INTEG_METHOD: method_r <= cfg_wdata[0];
          CFG_WINDUP_CLEAR: windup_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      out_valid_r <= out_valid_nxt;
      if (ctrl.en) begin
        case (ctrl.op)
          OP_ACC_INT: integ_r <= sadd(integ_r, fix_v);
          OP_DIV_END: last_r  <= e_r;
          OP_CLAMP: begin
            if (clip && windup_r) integ_r <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      ref_r  <= in_data.reference;
      meas_r <= in_data.measurement;
      dt_r   <= in_data.time_step;
    end
    if (ctrl.en && (ctrl.msrc != MS_NONE)) begin
      prod_r     <= mul_a * mul_b;
      prod_neg_r <= mul_neg;
    end
    if (ctrl.en) begin
      case (ctrl.op)
        OP_ERR: e_r <= ssub(ref_r, meas_r);
        OP_TERM: begin
          term_r <= method_r ? fmean(e_r, last_r) : e_r;
          diff_r <= ssub(e_r, last_r);
        end
        OP_DIV_INIT: begin
          num_r  <= {mag_of(diff_r), {FRAC_W{1'b0}}};
          rem_r  <= '0;
          cnt_r  <= CNT_W'(NUM_W - 1);
          dneg_r <= diff_r[DATA_W-1];
        end
        OP_DIV_STEP: begin
          rem_r <= qbit ? rem_dif[DATA_W-1:0] : rem_sh[DATA_W-1:0];
          num_r <= {num_r[NUM_W-2:0], qbit};
          cnt_r <= cnt_r - 1'b1;
        end
        // no change in error gives zero even for a zero time step
        OP_DIV_END: deriv_r <= (diff_r == '0) ? '0 : sat_mag(dneg_r, prod_t'(num_r));
        OP_ADD_P:   u_r <= fix_v;
        OP_ADD_I:   u_r <= sadd(u_r, fix_v);
        OP_ADD_D:   u_r <= sadd(u_r, fix_v);
        OP_CLAMP: begin
          drive_r <= below ? lo_r : (above ? hi_r : u_r);
          clip_r  <= clip;
        end
        default: ;
      endcase
    end
  end
endmodule

### hdl/pid_controller_clamped_unit.sv
// Channel  Dir  Handshake           Word
// in_ch    in   valid/ready         reference, measurement, time_step
// out_ch   out  valid/ready         drive, clamped
// cfg_*    in   cfg_we, no stall    cfg_idx selects register, cfg_wdata
//
// One word at a time: a new input word is accepted only after the previous
// one has run to the end. The microprogram runs 13 steps plus 48
// steps of the bit-serial divider by time_step, which make up most of the run.
// Synchronous active-low reset; configuration registers, integral and last error
// come up at their reset values and no clearing pass is needed.
// A result waiting on out_ch does not block input; the final step holds only
// if the previous result is still not taken.
module pid_controller_clamped_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  pcc_in_if.sink                        in_ch,
  pcc_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [pcc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [pcc_pkg::DATA_W-1:0]    cfg_wdata
);
  import pcc_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  in_ready;

  assign in_ch.ready = in_ready;

  pcc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  pcc_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .stat      (stat),
    .in_data   (in_ch.data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );
endmodule

### hdl/pcc_checker.sv
module pcc_props (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input pcc_pkg::out_item_t out_data
);
  import pcc_pkg::*;

  // a waiting result holds its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one word in flight: input closes right after acceptance
  a_in_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // a new result only comes out of a busy block
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without work in progress");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");
endmodule

bind pid_controller_clamped_unit pcc_props u_pcc_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
